### rtl/core/sdp_pkg.sv
package sdp_pkg;

  localparam logic [7:0]  START_BYTE = 8'hFE;
  localparam logic [10:0] DUTY_MAX   = 11'd1999;
  localparam logic [10:0] SERVO_BASE = 11'd99;
  localparam logic [8:0]  ANGLE_FULL = 9'd180;
  localparam logic [9:0]  RIGHT_CAP  = 10'd181;

  // floor(y / 9) == (y * SERVO_RECIP) >> SERVO_SHIFT for y below 2048
  localparam logic [12:0] SERVO_RECIP = 13'd7282;
  localparam int          SERVO_SHIFT = 16;

  localparam int CFG_INDEX_W = 3;
  localparam int CFG_DATA_W  = 8;

  localparam logic [CFG_INDEX_W-1:0] REG_RIGHT_THRESHOLD = 3'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_LEFT_THRESHOLD  = 3'd1;
  localparam logic [CFG_INDEX_W-1:0] REG_TURN_OFFSET     = 3'd2;
  localparam logic [CFG_INDEX_W-1:0] REG_TURN_BOOST      = 3'd3;
  localparam logic [CFG_INDEX_W-1:0] REG_SPEED_SCALE     = 3'd4;

  typedef struct packed {
    logic [7:0] right_threshold;
    logic [7:0] left_threshold;
    logic [5:0] turn_offset;
    logic [5:0] turn_boost;
    logic [4:0] speed_scale;
  } cfg_t;

  typedef struct packed {
    logic [7:0] angle;
    logic [7:0] speed;
  } frame_t;

  typedef struct packed {
    logic [10:0] servo_right;
    logic [10:0] servo_left;
    logic [10:0] motor_forward;
    logic [10:0] motor_reverse;
  } duty_t;

  // 99 + 100*x/180, i.e. 99 + floor(5x/9)
  function automatic logic [10:0] servo_map(input logic [8:0] x);
    logic [10:0] y;
    logic [23:0] prod;
    logic [10:0] v;
    y    = {2'b00, x} + {x, 2'b00};
    prod = {13'd0, y} * {11'd0, SERVO_RECIP};
    v    = SERVO_BASE + {3'd0, prod[SERVO_SHIFT +: 8]};
    return (v > DUTY_MAX) ? DUTY_MAX : v;
  endfunction

endpackage

### rtl/core/sdp_fifo.sv
module sdp_fifo #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 2
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             wr_en,
  input  logic [WIDTH-1:0] wr_data,
  output logic             full,
  input  logic             rd_en,
  output logic [WIDTH-1:0] rd_data,
  output logic             empty
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
  localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;

  logic do_wr;
  logic do_rd;

  assign full    = (count == CNT_FULL);
  assign empty   = (count == '0);
  assign do_wr   = wr_en && !full;
  assign do_rd   = rd_en && !empty;
  assign rd_data = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (do_wr) begin
      mem[wr_ptr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_wr) begin
        wr_ptr <= (wr_ptr == PTR_LAST) ? '0 : wr_ptr + 1'b1;
      end
      if (do_rd) begin
        rd_ptr <= (rd_ptr == PTR_LAST) ? '0 : rd_ptr + 1'b1;
      end
      case ({do_wr, do_rd})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

endmodule

### rtl/core/sdp_front.sv
module sdp_front (
  input  logic            clk,
  input  logic            rst,
  input  logic            push,
  input  logic [7:0]      rx_byte,
  output logic            full,
  output logic            q_push,
  output sdp_pkg::frame_t q_data,
  input  logic            q_full
);

  typedef enum logic [1:0] {
    HUNT,
    GET_ANGLE,
    GET_SPEED,
    GET_CHECK
  } phase_t;

  phase_t     phase;
  logic [7:0] angle;
  logic [7:0] speed;
  logic       take;

  assign full         = q_full;
  assign take         = push && !q_full;
  assign q_data.angle = angle;
  assign q_data.speed = speed;
  // a good check byte hands the frame to the queue, a bad one just drops it
  assign q_push = take && (phase == GET_CHECK) && ((angle ^ speed) == rx_byte);

  always_ff @(posedge clk) begin
    if (rst) begin
      phase <= HUNT;
      angle <= '0;
      speed <= '0;
    end else if (take) begin
      case (phase)
        HUNT: begin
          if (rx_byte == sdp_pkg::START_BYTE) begin
            phase <= GET_ANGLE;
          end
        end
        GET_ANGLE: begin
          angle <= rx_byte;
          phase <= GET_SPEED;
        end
        GET_SPEED: begin
          speed <= rx_byte;
          phase <= GET_CHECK;
        end
        GET_CHECK: phase <= HUNT;
        default:   phase <= HUNT;
      endcase
    end
  end

endmodule

### rtl/core/sdp_back.sv
module sdp_back (
  input  logic            clk,
  input  logic            rst,
  input  sdp_pkg::cfg_t   cfg,
  input  logic            q_empty,
  input  sdp_pkg::frame_t q_data,
  output logic            q_pop,
  output logic            res_push,
  output sdp_pkg::duty_t  res_data,
  input  logic            res_full
);

  logic        s1_valid;
  logic [8:0]  s1_right;
  logic [7:0]  s1_left;
  logic [10:0] s1_duty;
  logic        s1_reverse;

  logic [8:0]  right_base;
  logic [9:0]  right_boost;
  logic [8:0]  right_next;
  logic [7:0]  left_base;
  logic [7:0]  left_next;
  logic [7:0]  mag;
  logic [12:0] prod;
  logic [10:0] duty_next;
  logic        advance;
  logic        load;

  assign advance = s1_valid && !res_full;
  assign load    = !q_empty && (!s1_valid || advance);
  assign q_pop   = load;

  always_comb begin
    right_base  = {1'b0, q_data.angle} + {3'd0, cfg.turn_offset};
    left_base   = (q_data.angle > {2'd0, cfg.turn_offset}) ?
                  q_data.angle - {2'd0, cfg.turn_offset} : 8'd0;
    right_boost = {1'b0, right_base} + {4'd0, cfg.turn_boost};
    right_next  = right_base;
    left_next   = left_base;
    if (right_base > {1'b0, cfg.right_threshold}) begin
      // past full angle the right side is left alone
      if (right_base <= sdp_pkg::ANGLE_FULL) begin
        right_next = (right_boost > sdp_pkg::RIGHT_CAP) ?
                     sdp_pkg::RIGHT_CAP[8:0] : right_boost[8:0];
      end
    end else if (left_base < cfg.left_threshold) begin
      left_next = (left_base > {2'd0, cfg.turn_boost}) ?
                  left_base - {2'd0, cfg.turn_boost} : 8'd0;
    end

    // two's complement negate keeps -128 as magnitude 128
    mag       = q_data.speed[7] ? 8'(~q_data.speed + 8'd1) : q_data.speed;
    prod      = {5'd0, mag} * {8'd0, cfg.speed_scale};
    duty_next = (prod > {2'd0, sdp_pkg::DUTY_MAX}) ? sdp_pkg::DUTY_MAX : prod[10:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (load) begin
      s1_valid <= 1'b1;
    end else if (advance) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      s1_right   <= right_next;
      s1_left    <= left_next;
      s1_duty    <= duty_next;
      s1_reverse <= q_data.speed[7];
    end
  end

  assign res_push               = advance;
  assign res_data.servo_right   = sdp_pkg::servo_map(s1_right);
  assign res_data.servo_left    = sdp_pkg::servo_map({1'b0, s1_left});
  assign res_data.motor_forward = s1_reverse ? 11'd0 : s1_duty;
  assign res_data.motor_reverse = s1_reverse ? s1_duty : 11'd0;

endmodule

### rtl/core/steer_drive_packet_to_pwm.sv
// Packet decoder for steering and drive commands. One received byte is taken
// every clock while full is low; the front parser hunts for the 0xFE start
// byte, gathers angle, speed and check bytes, and passes each frame whose
// check matches into a short frame queue. The back end takes one frame per
// clock from that queue while the result queue has room, through a datapath
// (steering offset/boost and speed scaling, a stage register, then the servo
// mapping multiply) into a result queue. Results are drained one per clock
// with pop while empty is low. A stall on pop backs up the result queue, then
// the frame queue, and only then raises full. Configuration writes are always
// ready and take effect immediately; write them only while no frame is in
// flight.
module steer_drive_packet_to_pwm #(
  parameter int QUEUE_DEPTH = 2,
  parameter int RESULT_DEPTH = 2
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             push,
  output logic                             full,
  input  logic [7:0]                       rx_byte,
  output logic                             empty,
  input  logic                             pop,
  output logic [10:0]                      servo_right_duty,
  output logic [10:0]                      servo_left_duty,
  output logic [10:0]                      motor_forward_duty,
  output logic [10:0]                      motor_reverse_duty,
  input  logic                             cfg_valid,
  output logic                             cfg_ready,
  input  logic [sdp_pkg::CFG_INDEX_W-1:0]  cfg_index,
  input  logic [sdp_pkg::CFG_DATA_W-1:0]   cfg_data
);

  sdp_pkg::cfg_t   cfg;
  sdp_pkg::frame_t fq_wr_data;
  sdp_pkg::frame_t fq_rd_data;
  sdp_pkg::duty_t  rq_wr_data;
  sdp_pkg::duty_t  rq_rd_data;

  logic fq_push;
  logic fq_full;
  logic fq_pop;
  logic fq_empty;
  logic rq_push;
  logic rq_full;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.right_threshold <= 8'd102;
      cfg.left_threshold  <= 8'd78;
      cfg.turn_offset     <= 6'd12;
      cfg.turn_boost      <= 6'd20;
      cfg.speed_scale     <= 5'd19;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        sdp_pkg::REG_RIGHT_THRESHOLD: cfg.right_threshold <= cfg_data[7:0];
        sdp_pkg::REG_LEFT_THRESHOLD:  cfg.left_threshold  <= cfg_data[7:0];
        sdp_pkg::REG_TURN_OFFSET:     cfg.turn_offset     <= cfg_data[5:0];
        sdp_pkg::REG_TURN_BOOST:      cfg.turn_boost      <= cfg_data[5:0];
        sdp_pkg::REG_SPEED_SCALE:     cfg.speed_scale     <= cfg_data[4:0];
        default:                      cfg <= cfg;
      endcase
    end
  end

  sdp_front u_front (
    .clk     (clk),
    .rst     (rst),
    .push    (push),
    .rx_byte (rx_byte),
    .full    (full),
    .q_push  (fq_push),
    .q_data  (fq_wr_data),
    .q_full  (fq_full)
  );

  sdp_fifo #(
    .WIDTH ($bits(sdp_pkg::frame_t)),
    .DEPTH (QUEUE_DEPTH)
  ) u_frame_q (
    .clk     (clk),
    .rst     (rst),
    .wr_en   (fq_push),
    .wr_data (fq_wr_data),
    .full    (fq_full),
    .rd_en   (fq_pop),
    .rd_data (fq_rd_data),
    .empty   (fq_empty)
  );

  sdp_back u_back (
    .clk      (clk),
    .rst      (rst),
    .cfg      (cfg),
    .q_empty  (fq_empty),
    .q_data   (fq_rd_data),
    .q_pop    (fq_pop),
    .res_push (rq_push),
    .res_data (rq_wr_data),
    .res_full (rq_full)
  );

  sdp_fifo #(
    .WIDTH ($bits(sdp_pkg::duty_t)),
    .DEPTH (RESULT_DEPTH)
  ) u_result_q (
    .clk     (clk),
    .rst     (rst),
    .wr_en   (rq_push),
    .wr_data (rq_wr_data),
    .full    (rq_full),
    .rd_en   (pop),
    .rd_data (rq_rd_data),
    .empty   (empty)
  );

  assign servo_right_duty   = rq_rd_data.servo_right;
  assign servo_left_duty    = rq_rd_data.servo_left;
  assign motor_forward_duty = rq_rd_data.motor_forward;
  assign motor_reverse_duty = rq_rd_data.motor_reverse;

endmodule

### test/steer_drive_packet_to_pwm_check.sv
`timescale 1ns / 100ps

module steer_drive_packet_to_pwm_check (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            push,
  input  logic                            full,
  input  logic [7:0]                      rx_byte,
  input  logic                            empty,
  input  logic                            pop,
  input  logic [10:0]                     servo_right_duty,
  input  logic [10:0]                     servo_left_duty,
  input  logic [10:0]                     motor_forward_duty,
  input  logic [10:0]                     motor_reverse_duty,
  input  logic                            cfg_valid,
  input  logic                            cfg_ready,
  input  logic [sdp_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  logic [sdp_pkg::CFG_DATA_W-1:0]  cfg_data,
  output int                              error_count,
  output int                              pending_count,
  output int                              frame_count
);

  localparam int SERVO_SPAN = 100;

  typedef enum logic [1:0] {HUNT, GET_ANGLE, GET_SPEED, GET_CHECK} parse_phase_t;

  sdp_pkg::cfg_t  regs;
  parse_phase_t   phase;
  logic [7:0]     angle_hold;
  logic [7:0]     speed_hold;
  sdp_pkg::duty_t duty_expected_q[$];
  int             errs = 0;
  int             frames = 0;

  function automatic logic [10:0] servo_duty(input int x);
    int v;
    v = int'(sdp_pkg::SERVO_BASE) + (SERVO_SPAN * x) / int'(sdp_pkg::ANGLE_FULL);
    if (v > int'(sdp_pkg::DUTY_MAX)) v = int'(sdp_pkg::DUTY_MAX);
    return 11'(v);
  endfunction

  function automatic sdp_pkg::duty_t frame_duties(input logic [7:0] angle,
                                                  input logic [7:0] speed,
                                                  input sdp_pkg::cfg_t c);
    int             right;
    int             left;
    int             mag;
    int             drive;
    sdp_pkg::duty_t d;
    right = int'(angle) + int'(c.turn_offset);
    left = (int'(angle) > int'(c.turn_offset)) ? int'(angle) - int'(c.turn_offset) : 0;
    if (right > int'(c.right_threshold)) begin
      // past full scale the right value is left alone
      if (right <= int'(sdp_pkg::ANGLE_FULL)) begin
        right = right + int'(c.turn_boost);
        if (right > int'(sdp_pkg::RIGHT_CAP)) right = int'(sdp_pkg::RIGHT_CAP);
      end
    end else if (left < int'(c.left_threshold)) begin
      left = (left > int'(c.turn_boost)) ? left - int'(c.turn_boost) : 0;
    end
    mag = speed[7] ? 256 - int'(speed) : int'(speed);
    drive = mag * int'(c.speed_scale);
    if (drive > int'(sdp_pkg::DUTY_MAX)) drive = int'(sdp_pkg::DUTY_MAX);
    d.servo_right = servo_duty(right);
    d.servo_left = servo_duty(left);
    d.motor_forward = speed[7] ? 11'd0 : 11'(drive);
    d.motor_reverse = speed[7] ? 11'(drive) : 11'd0;
    return d;
  endfunction

  task automatic check_field(input string name, input logic [10:0] want,
                             input logic [10:0] got);
    if (got !== want) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      errs++;
    end
  endtask

  always @(posedge clk) begin
    sdp_pkg::duty_t want;
    if (rst) begin
      regs.right_threshold = 8'd102;
      regs.left_threshold = 8'd78;
      regs.turn_offset = 6'd12;
      regs.turn_boost = 6'd20;
      regs.speed_scale = 5'd19;
      phase = HUNT;
      angle_hold = '0;
      speed_hold = '0;
      duty_expected_q.delete();
    end else begin
      // a result never leaves in the clock its check byte is taken, so pop goes first
      if (pop && !empty) begin
        if (duty_expected_q.size() == 0) begin
          $error("result with no frame waiting: right %0d left %0d fwd %0d rev %0d",
                 servo_right_duty, servo_left_duty, motor_forward_duty, motor_reverse_duty);
          errs++;
        end else begin
          want = duty_expected_q.pop_front();
          frames++;
          check_field("servo_right_duty", want.servo_right, servo_right_duty);
          check_field("servo_left_duty", want.servo_left, servo_left_duty);
          check_field("motor_forward_duty", want.motor_forward, motor_forward_duty);
          check_field("motor_reverse_duty", want.motor_reverse, motor_reverse_duty);
        end
      end
      if (push && !full) begin
        case (phase)
          HUNT: if (rx_byte == sdp_pkg::START_BYTE) phase = GET_ANGLE;
          GET_ANGLE: begin
            angle_hold = rx_byte;
            phase = GET_SPEED;
          end
          GET_SPEED: begin
            speed_hold = rx_byte;
            phase = GET_CHECK;
          end
          default: begin
            phase = HUNT;
            if ((angle_hold ^ speed_hold) == rx_byte)
              duty_expected_q.push_back(frame_duties(angle_hold, speed_hold, regs));
          end
        endcase
      end
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          sdp_pkg::REG_RIGHT_THRESHOLD: regs.right_threshold = cfg_data;
          sdp_pkg::REG_LEFT_THRESHOLD:  regs.left_threshold = cfg_data;
          sdp_pkg::REG_TURN_OFFSET:     regs.turn_offset = cfg_data[5:0];
          sdp_pkg::REG_TURN_BOOST:      regs.turn_boost = cfg_data[5:0];
          sdp_pkg::REG_SPEED_SCALE:     regs.speed_scale = cfg_data[4:0];
          default: ;
        endcase
      end
    end
    error_count <= errs;
    pending_count <= duty_expected_q.size();
    frame_count <= frames;
  end

endmodule

### test/steer_drive_packet_to_pwm_test.sv
`timescale 1ns / 100ps

module steer_drive_packet_to_pwm_test;

  localparam int STALL_LIMIT = 1000;
  localparam int DRAIN_CYCLES = 16;
  localparam int PHASE_BYTES = 265;

  logic                            clk = 1'b0;
  logic                            rst = 1'b1;
  logic                            push = 1'b0;
  logic [7:0]                      rx_byte = '0;
  logic                            pop = 1'b0;
  logic                            cfg_valid = 1'b0;
  logic [sdp_pkg::CFG_INDEX_W-1:0] cfg_index = '0;
  logic [sdp_pkg::CFG_DATA_W-1:0]  cfg_data = '0;
  logic                            full;
  logic                            empty;
  logic                            cfg_ready;
  logic [10:0]                     servo_right_duty;
  logic [10:0]                     servo_left_duty;
  logic [10:0]                     motor_forward_duty;
  logic [10:0]                     motor_reverse_duty;

  int check_errors;
  int pending;
  int frames_checked;
  int push_idle_pct = 18;
  int pop_idle_pct = 18;
  int bytes_sent = 0;
  int settings_used = 1;
  int stall_cycles = 0;

  always #4 clk = ~clk;

  steer_drive_packet_to_pwm DUT (
    .clk(clk), .rst(rst), .push(push), .full(full), .rx_byte(rx_byte),
    .empty(empty), .pop(pop),
    .servo_right_duty(servo_right_duty), .servo_left_duty(servo_left_duty),
    .motor_forward_duty(motor_forward_duty), .motor_reverse_duty(motor_reverse_duty),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  steer_drive_packet_to_pwm_check duty_check (
    .clk(clk), .rst(rst), .push(push), .full(full), .rx_byte(rx_byte),
    .empty(empty), .pop(pop),
    .servo_right_duty(servo_right_duty), .servo_left_duty(servo_left_duty),
    .motor_forward_duty(motor_forward_duty), .motor_reverse_duty(motor_reverse_duty),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .error_count(check_errors), .pending_count(pending), .frame_count(frames_checked)
  );

  always @(posedge clk) begin
    pop <= !rst && ($urandom_range(0, 99) >= pop_idle_pct);
  end

  always @(posedge clk) begin
    if (rst || (push && !full) || (pop && !empty) || (cfg_valid && cfg_ready)) begin
      stall_cycles <= 0;
    end else if (stall_cycles == STALL_LIMIT) begin
      $display("watchdog: no item moved for %0d cycles", STALL_LIMIT);
      $display("TB_ERROR");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  task automatic send_byte(input logic [7:0] b);
    while ($urandom_range(0, 99) < push_idle_pct) begin
      push <= 1'b0;
      @(posedge clk);
    end
    push <= 1'b1;
    rx_byte <= b;
    @(posedge clk);
    while (full) @(posedge clk);
    bytes_sent++;
  endtask

  task automatic send_frame(input logic [7:0] angle, input logic [7:0] speed,
                            input logic check_ok);
    logic [7:0] chk;
    chk = angle ^ speed;
    if (!check_ok) chk = chk ^ 8'($urandom_range(1, 255));
    send_byte(sdp_pkg::START_BYTE);
    send_byte(angle);
    send_byte(speed);
    send_byte(chk);
  endtask

  // the last check byte may still be in the pipe even with nothing expected
  task automatic drain;
    push <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic cfg_put(input logic [sdp_pkg::CFG_INDEX_W-1:0] idx,
                         input logic [sdp_pkg::CFG_DATA_W-1:0] d);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= d;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
  endtask

  task automatic program_regs(input logic [7:0] rt, input logic [7:0] lt,
                              input logic [5:0] off, input logic [5:0] boost,
                              input logic [4:0] scale);
    cfg_put(sdp_pkg::REG_RIGHT_THRESHOLD, rt);
    cfg_put(sdp_pkg::REG_LEFT_THRESHOLD, lt);
    // junk in the unused upper bits must be dropped
    cfg_put(sdp_pkg::REG_TURN_OFFSET, {2'($urandom_range(0, 3)), off});
    cfg_put(sdp_pkg::REG_TURN_BOOST, {2'($urandom_range(0, 3)), boost});
    cfg_put(sdp_pkg::REG_SPEED_SCALE, {3'($urandom_range(0, 7)), scale});
    // out of range index, ignored
    cfg_put(sdp_pkg::REG_SPEED_SCALE + 3'($urandom_range(1, 3)),
            8'($urandom_range(0, 255)));
    cfg_valid <= 1'b0;
    settings_used++;
  endtask

  task automatic program_random;
    program_regs(8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
                 6'($urandom_range(0, 63)), 6'($urandom_range(0, 63)),
                 5'($urandom_range(0, 31)));
  endtask

  task automatic random_traffic(input int n);
    int         stop;
    int         roll;
    logic [7:0] a;
    logic [7:0] s;
    stop = bytes_sent + n;
    while (bytes_sent < stop) begin
      roll = $urandom_range(0, 99);
      a = 8'($urandom_range(0, 255));
      s = 8'($urandom_range(0, 255));
      if ($urandom_range(0, 9) == 0) a = $urandom_range(0, 1) ? 8'hFF : 8'h00;
      if ($urandom_range(0, 7) == 0) begin
        case ($urandom_range(0, 3))
          0: s = 8'h00;
          1: s = 8'h7F;
          2: s = 8'h80;
          default: s = 8'hFF;
        endcase
      end
      if (roll < 75) begin
        send_frame(a, s, 1'b1);
      end else if (roll < 85) begin
        send_frame(a, s, 1'b0);
      end else if (roll < 93) begin
        send_byte(8'($urandom_range(0, 255)));
      end else begin
        // cut-off frame, the parser has to find its way back
        send_byte(sdp_pkg::START_BYTE);
        repeat ($urandom_range(1, 2)) send_byte(8'($urandom_range(0, 255)));
      end
    end
  endtask

  initial begin
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // reset register values
    send_byte(8'h00);
    send_byte(8'hFF);
    send_frame(8'd0, 8'h00, 1'b1);
    send_frame(8'd255, 8'h80, 1'b1);
    send_frame(8'd90, 8'h7F, 1'b1);
    send_frame(8'd165, 8'hFF, 1'b1);
    send_frame(8'd60, 8'h81, 1'b1);
    send_frame(8'd60, 8'h81, 1'b0);
    random_traffic(PHASE_BYTES);

    drain;
    program_regs(8'd0, 8'd0, 6'd0, 6'd0, 5'd0);
    random_traffic(PHASE_BYTES);

    drain;
    program_regs(8'd255, 8'd255, 6'd63, 6'd63, 5'd31);
    random_traffic(PHASE_BYTES);

    drain;
    program_random;
    random_traffic(PHASE_BYTES);

    // back to back, no gaps on either side
    drain;
    push_idle_pct = 0;
    pop_idle_pct = 0;
    program_random;
    random_traffic(PHASE_BYTES);

    drain;
    push_idle_pct = 18;
    pop_idle_pct = 18;
    program_random;
    random_traffic(PHASE_BYTES);

    drain;
    $display("%0d bytes sent under %0d register settings", bytes_sent, settings_used);
    $display("%0d frames decoded and compared, %0d mismatches", frames_checked, check_errors);
    if (check_errors == 0 && pending == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule

### steer_drive_packet_to_pwm.f
rtl/core/sdp_pkg.sv
rtl/core/sdp_fifo.sv
rtl/core/sdp_front.sv
rtl/core/sdp_back.sv
rtl/core/steer_drive_packet_to_pwm.sv
test/steer_drive_packet_to_pwm_check.sv
test/steer_drive_packet_to_pwm_test.sv
